[sv/rcnt_pkg.sv]
// Shared types and constants for the three-channel root counter timer.
// Used by rcnt_channel, the top level and the port checker; no dependencies.
package rcnt_pkg;

  localparam int NUM_COUNTERS = 3;
  localparam int FUNC_W       = 3;
  localparam int IDX_W        = 2;
  localparam int DATA_W       = 16;
  localparam int IRQ_W        = 3;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 24;

  // Access codes carried in the func field
  typedef enum logic [FUNC_W-1:0] {
    FN_TICK      = 3'd0,
    FN_WR_COUNT  = 3'd1,
    FN_WR_MODE   = 3'd2,
    FN_WR_TARGET = 3'd3,
    FN_RD_COUNT  = 3'd4,
    FN_RD_MODE   = 3'd5,
    FN_RD_TARGET = 3'd6
  } func_t;

  // Channel identities
  localparam logic [IDX_W-1:0] CH_SYS    = 2'd0;
  localparam logic [IDX_W-1:0] CH_HSYNC  = 2'd1;
  localparam logic [IDX_W-1:0] CH_EIGHTH = 2'd2;

  // Mode word bits
  localparam logic [DATA_W-1:0] MODE_DISABLE2   = 16'h0001;
  localparam logic [DATA_W-1:0] MODE_CNT_TARGET = 16'h0008;
  localparam logic [DATA_W-1:0] MODE_IRQ_TARGET = 16'h0010;
  localparam logic [DATA_W-1:0] MODE_IRQ_OVF    = 16'h0020;
  localparam logic [DATA_W-1:0] MODE_REGEN      = 16'h0040;
  localparam logic [DATA_W-1:0] MODE_CLK_SEL    = 16'h0100;
  localparam logic [DATA_W-1:0] MODE_EIGHTH     = 16'h0200;
  localparam logic [DATA_W-1:0] MODE_EVENT      = 16'h0400;
  localparam logic [DATA_W-1:0] MODE_HIT_TARGET = 16'h0800;
  localparam logic [DATA_W-1:0] MODE_HIT_OVF    = 16'h1000;
  localparam logic [DATA_W-1:0] MODE_READ_KEEP  = 16'he7ff;

  localparam logic [DATA_W-1:0] COUNT_TOP    = 16'hffff;
  localparam logic [DATA_W-1:0] RATE_ONE     = 16'd1;
  localparam logic [DATA_W-1:0] RATE_FIFTH   = 16'd5;
  localparam logic [DATA_W-1:0] RATE_EIGHTH  = 16'd8;
  localparam logic [DATA_W-1:0] HSYNC_RESET  = 16'd2146;

  // One decoded request as seen by a channel
  typedef struct packed {
    func_t             func;
    logic              sel;
    logic [DATA_W-1:0] wval;
  } acc_t;

endpackage

[sv/rcnt_channel.sv]
// One 16-bit root counter: count, target, mode, prescaler and irq latch.
// Depends on rcnt_pkg; instantiated once per channel by the top level.
module rcnt_channel (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rcnt_pkg::IDX_W-1:0]  chan_id,
  input  logic                        en,
  input  rcnt_pkg::acc_t              acc,
  input  logic [rcnt_pkg::DATA_W-1:0] hsync_div,
  output logic [rcnt_pkg::DATA_W-1:0] rd_data,
  output logic                        irq
);

  logic [rcnt_pkg::DATA_W-1:0] count_r,  count_nxt;
  logic [rcnt_pkg::DATA_W-1:0] target_r, target_nxt;
  logic [rcnt_pkg::DATA_W-1:0] mode_r,   mode_nxt;
  logic [rcnt_pkg::DATA_W-1:0] pre_r,    pre_nxt;
  logic                        latch_r,  latch_nxt;
  logic                        toward_r, toward_nxt;

  logic [rcnt_pkg::DATA_W-1:0] pre_inc;
  logic [rcnt_pkg::DATA_W-1:0] rate;
  logic [rcnt_pkg::DATA_W:0]   step;
  logic                        halted;
  logic                        irq_en;

  // Select the prescaler period for this channel
  always_comb begin
    case (chan_id)
      rcnt_pkg::CH_SYS: begin
        rate = ((mode_r & rcnt_pkg::MODE_CLK_SEL) != '0) ? rcnt_pkg::RATE_FIFTH
                                                          : rcnt_pkg::RATE_ONE;
      end
      rcnt_pkg::CH_HSYNC: begin
        if ((mode_r & rcnt_pkg::MODE_CLK_SEL) == '0) begin
          rate = rcnt_pkg::RATE_ONE;
        end else begin
          rate = (hsync_div == '0) ? rcnt_pkg::RATE_ONE : hsync_div;
        end
      end
      default: begin
        rate = ((mode_r & rcnt_pkg::MODE_EIGHTH) != '0) ? rcnt_pkg::RATE_EIGHTH
                                                         : rcnt_pkg::RATE_ONE;
      end
    endcase
  end

  assign halted  = (chan_id == rcnt_pkg::CH_EIGHTH) &&
                   ((mode_r & rcnt_pkg::MODE_DISABLE2) != '0);
  assign pre_inc = pre_r + rcnt_pkg::DATA_W'(1);

  // Work out the next state and the result for the request
  always_comb begin
    count_nxt  = count_r;
    target_nxt = target_r;
    mode_nxt   = mode_r;
    pre_nxt    = pre_r;
    latch_nxt  = latch_r;
    toward_nxt = toward_r;
    rd_data    = '0;
    irq        = 1'b0;
    irq_en     = 1'b0;
    step       = {1'b0, count_r} + (rcnt_pkg::DATA_W+1)'(1);
    case (acc.func)
      rcnt_pkg::FN_TICK: begin
        if (!halted) begin
          if (pre_inc < rate) begin
            pre_nxt = pre_inc;
          end else begin
            pre_nxt = '0;
            if (toward_r && (step >= {1'b0, target_r})) begin
              // target reached
              if ((mode_r & rcnt_pkg::MODE_CNT_TARGET) != '0) begin
                step = step - {1'b0, target_r};
              end
              irq_en     = (mode_r & rcnt_pkg::MODE_IRQ_TARGET) != '0;
              mode_nxt   = mode_r | rcnt_pkg::MODE_HIT_TARGET | rcnt_pkg::MODE_EVENT;
              count_nxt  = step[rcnt_pkg::DATA_W-1:0];
              toward_nxt = step[rcnt_pkg::DATA_W-1:0] < target_r;
            end else if (!toward_r && (step >= {1'b0, rcnt_pkg::COUNT_TOP})) begin
              // overflow reached
              step       = step - {1'b0, rcnt_pkg::COUNT_TOP};
              irq_en     = (mode_r & rcnt_pkg::MODE_IRQ_OVF) != '0;
              mode_nxt   = mode_r | rcnt_pkg::MODE_HIT_OVF | rcnt_pkg::MODE_EVENT;
              count_nxt  = step[rcnt_pkg::DATA_W-1:0];
              toward_nxt = step[rcnt_pkg::DATA_W-1:0] < target_r;
            end else begin
              count_nxt = step[rcnt_pkg::DATA_W-1:0];
            end
            // fire once unless regenerate is set
            if (irq_en && (((mode_r & rcnt_pkg::MODE_REGEN) != '0) || !latch_r)) begin
              irq       = 1'b1;
              latch_nxt = 1'b1;
            end
          end
        end
      end
      rcnt_pkg::FN_WR_COUNT: begin
        if (acc.sel) begin
          count_nxt  = acc.wval;
          pre_nxt    = '0;
          toward_nxt = acc.wval < target_r;
        end
      end
      rcnt_pkg::FN_WR_MODE: begin
        if (acc.sel) begin
          mode_nxt   = acc.wval;
          latch_nxt  = 1'b0;
          count_nxt  = '0;
          pre_nxt    = '0;
          toward_nxt = target_r != '0;
        end
      end
      rcnt_pkg::FN_WR_TARGET: begin
        if (acc.sel) begin
          target_nxt = acc.wval;
          pre_nxt    = '0;
          toward_nxt = count_r < acc.wval;
        end
      end
      rcnt_pkg::FN_RD_COUNT: begin
        if (acc.sel) begin
          rd_data = count_r;
        end
      end
      rcnt_pkg::FN_RD_MODE: begin
        if (acc.sel) begin
          rd_data  = mode_r;
          mode_nxt = mode_r & rcnt_pkg::MODE_READ_KEEP;
        end
      end
      rcnt_pkg::FN_RD_TARGET: begin
        if (acc.sel) begin
          rd_data = target_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold state; advance only when the request is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      target_r <= '0;
      mode_r   <= '0;
      pre_r    <= '0;
      latch_r  <= 1'b0;
      toward_r <= 1'b0;
    end else if (en) begin
      count_r  <= count_nxt;
      target_r <= target_nxt;
      mode_r   <= mode_nxt;
      pre_r    <= pre_nxt;
      latch_r  <= latch_nxt;
      toward_r <= toward_nxt;
    end
  end

endmodule

[sv/three_channel_root_counter_timer.sv]
// Top level of the three-channel root counter timer: request and result
// registers around the counter channels. Depends on rcnt_pkg and rcnt_channel.
//
// Usage:
//   Requests enter on the in_ stream (func, index, write_value). Each request
//   is a tick that advances every counter by one system cycle, or a register
//   access to one counter. Every request yields exactly one result on the
//   out_ stream: read_data for reads, zero otherwise, and one irq bit per
//   counter that raised its interrupt on that tick.
//   cfg_ writes set the hsync divider used by counter one; write it only
//   while no requests are in flight. cfg_ready is always high.
// Timing:
//   A request goes into the request register, is processed by the channels,
//   and its result is captured in the result register, which drives
//   out_tvalid. One request per cycle is sustained while out_tready
//   stays high.
// Reset (rst_n low, synchronous) clears all counters, modes, targets and
//   prescalers, sets the hsync divider to 2146 and empties both registers.
// A stalled receiver holds the result; the request register still fills,
//   after which in_tready drops until the result is taken.
module three_channel_root_counter_timer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [2:0] func, [4:3] index, [20:5] write_value, [23:21] zero
  input  logic [rcnt_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] read_data, [18:16] irq_fired, [23:19] zero
  output logic [rcnt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rcnt_pkg::DATA_W-1:0]      cfg_data
);

  logic                              in_valid_r;
  logic [rcnt_pkg::FUNC_W-1:0]       func_r;
  logic [rcnt_pkg::IDX_W-1:0]        index_r;
  logic [rcnt_pkg::DATA_W-1:0]       wval_r;
  logic                              out_valid_r;
  logic [rcnt_pkg::DATA_W-1:0]       rd_r, rd_nxt;
  logic [rcnt_pkg::IRQ_W-1:0]        irq_r, irq_nxt;
  logic [rcnt_pkg::DATA_W-1:0]       hsync_r;
  logic                              advance;
  logic [rcnt_pkg::DATA_W-1:0]       ch_rd  [rcnt_pkg::NUM_COUNTERS];
  logic [rcnt_pkg::NUM_COUNTERS-1:0] ch_irq;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  // Capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      func_r  <= in_tdata[2:0];
      index_r <= in_tdata[4:3];
      wval_r  <= in_tdata[20:5];
    end
  end

  // Hold the hsync divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hsync_r <= rcnt_pkg::HSYNC_RESET;
    end else if (cfg_valid) begin
      hsync_r <= cfg_data;
    end
  end

  // One channel per counter
  for (genvar g = 0; g < rcnt_pkg::NUM_COUNTERS; g++) begin : g_ch
    rcnt_pkg::acc_t acc;
    assign acc.func = rcnt_pkg::func_t'(func_r);
    assign acc.sel  = (index_r == rcnt_pkg::IDX_W'(g));
    assign acc.wval = wval_r;

    rcnt_channel u_ch (
      .clk       (clk),
      .rst_n     (rst_n),
      .chan_id   (rcnt_pkg::IDX_W'(g)),
      .en        (advance),
      .acc       (acc),
      .hsync_div (hsync_r),
      .rd_data   (ch_rd[g]),
      .irq       (ch_irq[g])
    );
  end

  // Merge channel results; unselected channels drive zero
  always_comb begin
    rd_nxt  = '0;
    irq_nxt = '0;
    for (int i = 0; i < rcnt_pkg::NUM_COUNTERS; i++) begin
      rd_nxt     = rd_nxt | ch_rd[i];
      irq_nxt[i] = ch_irq[i];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rd_r  <= rd_nxt;
      irq_r <= irq_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, irq_r, rd_r};

endmodule

[sv/rcnt_checker.sv]
// Port-level checks for the root counter timer, bound to the top level.
// Depends only on rcnt_pkg widths and the top level's ports.
module rcnt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rcnt_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Every accepted request is followed by a valid result on the out_ stream
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ##1 out_tvalid)
    else $error("no result after accepted request");

  // Interrupts come only from ticks, which return no read data
  a_irq_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[18:16] != 3'b0) |-> out_tdata[15:0] == 16'b0)
    else $error("irq and read data in one result");

  // Stalled result holds
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

endmodule

bind three_channel_root_counter_timer rcnt_checker u_rcnt_checker (.*);
